// ===== sv/iksv_pkg.sv =====
`timescale 1ns / 1ps
package iksv_pkg;
  localparam int CORDIC_STEPS = 22;
  localparam int CW = 56;
  localparam int AW = 26;
  localparam int IW = 31;
  localparam int PRESCALE_SH = 24;
  localparam int RHO_W = 29;
  localparam int DIV_W = 36;
  localparam int SQA_N = 16;
  localparam int SUM_W = 28;
  localparam int CENT_W = 19;
  localparam int CFG_W = 48;
  localparam int CFG_IDX_W = 3;
  localparam int PULSE_W = 11;
  localparam int PULSE_SHIFT = 38;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_FRONT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_FRONT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_HIND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_HIND = 3'd3;

  localparam logic signed [AW-1:0] QUARTER_TURN = 26'sd5898240;
  localparam logic signed [AW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379, 26'sd117304,
    26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334, 26'sd3667, 26'sd1833, 26'sd917,
    26'sd458, 26'sd229, 26'sd115, 26'sd57, 26'sd29, 26'sd14, 26'sd7, 26'sd4, 26'sd2
  };

  localparam logic [24:0] PULSE_RECIP = 25'd27487791;
  localparam logic signed [31:0] PULSE_SAT_N = 32'sd20480000;
  localparam logic signed [31:0] PULSE_GAIN = 32'sd556;
  localparam logic signed [31:0] PULSE_BIAS = 32'sd7500000;
  localparam logic [PULSE_W-1:0] PULSE_MAX = 11'd2047;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] ang;
    logic                 zero;
  } cordic_t;

  function automatic cordic_t cordic_pre(logic signed [IW-1:0] yin,
                                         logic signed [IW-1:0] xin);
    cordic_t c;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    xs = CW'(xin) <<< PRESCALE_SH;
    ys = CW'(yin) <<< PRESCALE_SH;
    c.zero = (xin == '0) && (yin == '0);
    if (xs < 0) begin
      if (ys >= 0) begin
        c.x = ys;
        c.y = -xs;
        c.ang = QUARTER_TURN;
      end else begin
        c.x = -ys;
        c.y = xs;
        c.ang = -QUARTER_TURN;
      end
    end else begin
      c.x = xs;
      c.y = ys;
      c.ang = '0;
    end
    return c;
  endfunction
endpackage

// ===== sv/iksv_if.sv =====
`timescale 1ns / 1ps
interface iksv_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         leg;
  logic signed [15:0] foot_x;
  logic signed [15:0] foot_y;
  logic signed [15:0] foot_z;
  modport source(output valid, leg, foot_x, foot_y, foot_z, input ready);
  modport sink(input valid, leg, foot_x, foot_y, foot_z, output ready);
endinterface

interface iksv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  leg_out;
  logic [10:0] pulse_joint_one;
  logic [10:0] pulse_joint_two;
  logic [10:0] pulse_joint_three;
  logic        reachable;
  modport source(output valid, leg_out, pulse_joint_one, pulse_joint_two, pulse_joint_three,
                 reachable, input ready);
  modport sink(input valid, leg_out, pulse_joint_one, pulse_joint_two, pulse_joint_three,
               reachable, output ready);
endinterface

// ===== sv/leg_inverse_kinematics_servo_unit.sv =====
`timescale 1ns / 1ps
// channel   | port     | direction | carries
// ----------+----------+-----------+--------------------------------------------
// input     | in_item  | sink      | leg, foot_x, foot_y, foot_z
// output    | out_item | source    | leg_out, pulse_joint_one/two/three, reachable
// config    | wr_*     | write     | wr_index 0..3 selects the leg offset register
//
// One item enters per cycle unless the chain holds; each passes from acceptance
// to the output register through square-root, divider and CORDIC cells in series.
// The whole chain holds while a result waits and out_item.ready is low.
// rst clears the valid chain and the offset registers; no clearing pass.
module leg_inverse_kinematics_servo_unit #(
  parameter int UPPER_LINK_MM = 38,
  parameter int LOWER_LINK_MM = 47,
  parameter int SIDE_LINK_MM = 22
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [iksv_pkg::CFG_IDX_W-1:0]       wr_index,
  input  logic [iksv_pkg::CFG_W-1:0]           wr_data,
  iksv_in_if.sink                              in_item,
  iksv_out_if.source                           out_item
);
  import iksv_pkg::*;

  localparam int NCH = 5;
  localparam int LAT = 2 + SQA_N + 2 + RHO_W + 1 + RHO_W + CORDIC_STEPS + 6;
  localparam logic [DIV_W-1:0] L1 = DIV_W'(UPPER_LINK_MM) << 8;
  localparam logic [DIV_W-1:0] L2 = DIV_W'(LOWER_LINK_MM) << 8;
  localparam logic [DIV_W-1:0] L3 = DIV_W'(SIDE_LINK_MM) << 8;
  localparam logic [DIV_W-1:0] L1SQ = L1 * L1;
  localparam logic [DIV_W-1:0] L2SQ = L2 * L2;
  localparam logic [DIV_W-1:0] L3SQ = L3 * L3;
  localparam logic [DIV_W-1:0] L1X2 = L1 << 1;
  localparam logic [DIV_W-1:0] D2 = L1X2 * L2;
  localparam logic signed [DIV_W-1:0] K1 = $signed(L1SQ - L2SQ - L3SQ);
  localparam logic signed [DIV_W-1:0] K2 = $signed(L1SQ + L2SQ + L3SQ);
  localparam logic signed [IW-1:0] NEG_L3 = -$signed(L3[IW-1:0]);
  localparam logic [2*RHO_W-1:0] UNIT_SQ = (2*RHO_W)'(1) << (2*(RHO_W-1));

  logic [LAT-1:0] vld;
  logic           en;
  logic [CFG_W-1:0] offs [4];

  assign en = !vld[LAT-1] || out_item.ready;
  assign in_item.ready = en;
  assign out_item.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_item.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) offs[i] <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_LEFT_FRONT:  offs[0] <= wr_data;
        REG_RIGHT_FRONT: offs[1] <= wr_data;
        REG_LEFT_HIND:   offs[2] <= wr_data;
        REG_RIGHT_HIND:  offs[3] <= wr_data;
        default: ;
      endcase
    end
  end

  // squares
  logic signed [31:0] xx, yy, zz;
  logic signed [15:0] s1_x, s1_y, s1_z;
  logic [1:0]         s1_leg;
  logic [30:0]        s1_x2, s1_y2, s1_z2;

  assign xx = in_item.foot_x * in_item.foot_x;
  assign yy = in_item.foot_y * in_item.foot_y;
  assign zz = in_item.foot_z * in_item.foot_z;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x <= in_item.foot_x;
      s1_y <= in_item.foot_y;
      s1_z <= in_item.foot_z;
      s1_leg <= in_item.leg;
      s1_x2 <= xx[30:0];
      s1_y2 <= yy[30:0];
      s1_z2 <= zz[30:0];
    end
  end

  // sums and range checks
  logic [31:0]              r_sum, d_sum;
  logic signed [DIV_W-1:0]  n2_next;
  logic signed [15:0]       s2_x, s2_y, s2_z;
  logic [1:0]               s2_leg;
  logic [31:0]              s2_d, s2_rm, s2_dm;
  logic                     s2_rok, s2_n2ok;
  logic signed [DIV_W-1:0]  s2_n2;

  assign r_sum = {1'b0, s1_y2} + {1'b0, s1_z2};
  assign d_sum = {1'b0, s1_x2} + r_sum;
  assign n2_next = K2 - $signed(DIV_W'(d_sum));

  always_ff @(posedge clk) begin
    if (en) begin
      s2_x <= s1_x;
      s2_y <= s1_y;
      s2_z <= s1_z;
      s2_leg <= s1_leg;
      s2_d <= d_sum;
      s2_rm <= r_sum - L3SQ[31:0];
      s2_dm <= d_sum - L3SQ[31:0];
      s2_rok <= DIV_W'(r_sum) >= L3SQ;
      s2_n2 <= n2_next;
      s2_n2ok <= (n2_next <= $signed(D2)) && (n2_next >= -$signed(D2));
    end
  end

  // first square roots
  logic [2*SQA_N-1:0] sa_v    [2][SQA_N+1];
  logic [SQA_N+2:0]   sa_rem  [2][SQA_N+1];
  logic [SQA_N-1:0]   sa_root [2][SQA_N+1];

  assign sa_v[0][0] = s2_rm;
  assign sa_v[1][0] = s2_dm;

  for (genvar c = 0; c < 2; c++) begin : g_sqa
    assign sa_rem[c][0] = '0;
    assign sa_root[c][0] = '0;
    for (genvar k = 0; k < SQA_N; k++) begin : g_cell
      iksv_sqrt_cell #(.N(SQA_N)) u_cell (
        .clk(clk), .en(en),
        .v_in(sa_v[c][k]), .rem_in(sa_rem[c][k]), .root_in(sa_root[c][k]),
        .v_out(sa_v[c][k+1]), .rem_out(sa_rem[c][k+1]), .root_out(sa_root[c][k+1])
      );
    end
  end

  logic signed [15:0]      a_x, a_y, a_z;
  logic [1:0]              a_leg;
  logic [31:0]             a_d;
  logic                    a_rok, a_n2ok;
  logic signed [DIV_W-1:0] a_n2;

  iksv_delay #(.W(48 + 2 + 32 + 2 + DIV_W), .DEPTH(SQA_N)) u_dly_a (
    .clk(clk), .en(en),
    .d({s2_x, s2_y, s2_z, s2_leg, s2_d, s2_rok, s2_n2ok, s2_n2}),
    .q({a_x, a_y, a_z, a_leg, a_d, a_rok, a_n2ok, a_n2})
  );

  // denominator and numerator of the first arc sine
  logic [SQA_N-1:0]        s19_side;
  logic signed [15:0]      s19_x, s19_y, s19_z;
  logic [1:0]              s19_leg;
  logic [DIV_W-1:0]        s19_d1;
  logic signed [DIV_W-1:0] s19_n1, s19_n2;
  logic                    s19_rok, s19_n2ok;

  always_ff @(posedge clk) begin
    if (en) begin
      s19_side <= sa_root[0][SQA_N];
      s19_x <= a_x;
      s19_y <= a_y;
      s19_z <= a_z;
      s19_leg <= a_leg;
      s19_d1 <= L1X2 * DIV_W'(sa_root[1][SQA_N]);
      s19_n1 <= $signed(DIV_W'(a_d)) + K1;
      s19_n2 <= a_n2;
      s19_rok <= a_rok;
      s19_n2ok <= a_n2ok;
    end
  end

  logic [SQA_N-1:0]   s20_side;
  logic signed [15:0] s20_x, s20_y, s20_z;
  logic [1:0]         s20_leg;
  logic               s20_reach, s20_neg1, s20_neg2;
  logic [DIV_W-1:0]   s20_mag1, s20_mag2, s20_den1;

  always_ff @(posedge clk) begin
    if (en) begin
      s20_side <= s19_side;
      s20_x <= s19_x;
      s20_y <= s19_y;
      s20_z <= s19_z;
      s20_leg <= s19_leg;
      s20_reach <= s19_rok && s19_n2ok && (s19_d1 != '0) &&
                   (s19_n1 <= $signed(s19_d1)) && (-s19_n1 <= $signed(s19_d1));
      s20_neg1 <= s19_n1 < 0;
      s20_neg2 <= s19_n2 < 0;
      s20_mag1 <= (s19_n1 < 0) ? DIV_W'(-s19_n1) : DIV_W'(s19_n1);
      s20_mag2 <= (s19_n2 < 0) ? DIV_W'(-s19_n2) : DIV_W'(s19_n2);
      s20_den1 <= s19_d1;
    end
  end

  // sine ratios
  logic [DIV_W-1:0] dv_rem [2][RHO_W+1];
  logic [DIV_W-1:0] dv_den [2][RHO_W+1];
  logic [RHO_W-1:0] dv_quo [2][RHO_W+1];

  assign dv_rem[0][0] = s20_mag1;
  assign dv_den[0][0] = s20_den1;
  assign dv_rem[1][0] = s20_mag2;
  assign dv_den[1][0] = D2;

  for (genvar c = 0; c < 2; c++) begin : g_div
    assign dv_quo[c][0] = '0;
    for (genvar k = 0; k < RHO_W; k++) begin : g_cell
      iksv_div_cell #(.FIRST(k == 0)) u_cell (
        .clk(clk), .en(en),
        .rem_in(dv_rem[c][k]), .den_in(dv_den[c][k]), .quo_in(dv_quo[c][k]),
        .rem_out(dv_rem[c][k+1]), .den_out(dv_den[c][k+1]), .quo_out(dv_quo[c][k+1])
      );
    end
  end

  logic [SQA_N-1:0]   b_side;
  logic signed [15:0] b_x, b_y, b_z;
  logic [1:0]         b_leg;
  logic               b_reach, b_neg1, b_neg2;

  iksv_delay #(.W(SQA_N + 48 + 2 + 3), .DEPTH(RHO_W)) u_dly_b (
    .clk(clk), .en(en),
    .d({s20_side, s20_x, s20_y, s20_z, s20_leg, s20_reach, s20_neg1, s20_neg2}),
    .q({b_side, b_x, b_y, b_z, b_leg, b_reach, b_neg1, b_neg2})
  );

  logic signed [RHO_W:0] s50_rho [2];
  logic [2*RHO_W-1:0]    s50_rsq [2];
  logic [SQA_N-1:0]      s50_side;
  logic signed [15:0]    s50_x, s50_y, s50_z;
  logic [1:0]            s50_leg;
  logic                  s50_reach;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 2; c++) begin
        s50_rsq[c] <= (2*RHO_W)'(dv_quo[c][RHO_W]) * (2*RHO_W)'(dv_quo[c][RHO_W]);
      end
      s50_rho[0] <= b_neg1 ? -$signed({1'b0, dv_quo[0][RHO_W]}) : $signed({1'b0, dv_quo[0][RHO_W]});
      s50_rho[1] <= b_neg2 ? -$signed({1'b0, dv_quo[1][RHO_W]}) : $signed({1'b0, dv_quo[1][RHO_W]});
      s50_side <= b_side;
      s50_x <= b_x;
      s50_y <= b_y;
      s50_z <= b_z;
      s50_leg <= b_leg;
      s50_reach <= b_reach;
    end
  end

  // cosine magnitudes
  logic [2*RHO_W-1:0] sb_v    [2][RHO_W+1];
  logic [RHO_W+2:0]   sb_rem  [2][RHO_W+1];
  logic [RHO_W-1:0]   sb_root [2][RHO_W+1];

  for (genvar c = 0; c < 2; c++) begin : g_sqb
    assign sb_v[c][0] = UNIT_SQ - s50_rsq[c];
    assign sb_rem[c][0] = '0;
    assign sb_root[c][0] = '0;
    for (genvar k = 0; k < RHO_W; k++) begin : g_cell
      iksv_sqrt_cell #(.N(RHO_W)) u_cell (
        .clk(clk), .en(en),
        .v_in(sb_v[c][k]), .rem_in(sb_rem[c][k]), .root_in(sb_root[c][k]),
        .v_out(sb_v[c][k+1]), .rem_out(sb_rem[c][k+1]), .root_out(sb_root[c][k+1])
      );
    end
  end

  logic signed [RHO_W:0] c_rho0, c_rho1;
  logic [SQA_N-1:0]      c_side;
  logic signed [15:0]    c_x, c_y, c_z;
  logic [1:0]            c_leg;
  logic                  c_reach;

  iksv_delay #(.W(2*(RHO_W+1) + SQA_N + 48 + 3), .DEPTH(RHO_W)) u_dly_c (
    .clk(clk), .en(en),
    .d({s50_rho[0], s50_rho[1], s50_side, s50_x, s50_y, s50_z, s50_leg, s50_reach}),
    .q({c_rho0, c_rho1, c_side, c_x, c_y, c_z, c_leg, c_reach})
  );

  // vectoring chains: side angle, hip angle, knee angle, two arc sines
  cordic_t cd [NCH][CORDIC_STEPS+1];

  assign cd[0][0] = cordic_pre(NEG_L3, $signed(IW'(c_side)));
  assign cd[1][0] = cordic_pre(IW'(c_z), -IW'(c_y));
  assign cd[2][0] = cordic_pre($signed(IW'(c_side)), IW'(c_x));
  assign cd[3][0] = cordic_pre(IW'(c_rho0), $signed(IW'(sb_root[0][RHO_W])));
  assign cd[4][0] = cordic_pre(IW'(c_rho1), $signed(IW'(sb_root[1][RHO_W])));

  for (genvar c = 0; c < NCH; c++) begin : g_cordic
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
      iksv_cordic_cell #(.STEP(k)) u_cell (
        .clk(clk), .en(en), .d(cd[c][k]), .q(cd[c][k+1])
      );
    end
  end

  logic [1:0] d_leg;
  logic       d_reach;

  iksv_delay #(.W(3), .DEPTH(CORDIC_STEPS)) u_dly_d (
    .clk(clk), .en(en), .d({c_leg, c_reach}), .q({d_leg, d_reach})
  );

  logic signed [SUM_W-1:0] ang [NCH];

  for (genvar c = 0; c < NCH; c++) begin : g_ang
    assign ang[c] = cd[c][CORDIC_STEPS].zero ? '0 : SUM_W'(cd[c][CORDIC_STEPS].ang);
  end

  // joint angles
  logic signed [SUM_W-1:0] s102_a0, s102_a1, s102_a2;
  logic [1:0]              s102_leg;
  logic                    s102_reach;

  always_ff @(posedge clk) begin
    if (en) begin
      s102_a0 <= ang[0] - ang[1];
      s102_a1 <= ang[3] - ang[2];
      s102_a2 <= ang[4];
      s102_leg <= d_leg;
      s102_reach <= d_reach;
    end
  end

  // index 0 outer, 1 middle, 2 inner
  logic signed [SUM_W-1:0] s103_ang [3];
  logic [1:0]              s103_leg;
  logic                    s103_reach;

  always_ff @(posedge clk) begin
    if (en) begin
      s103_ang[0] <= s102_a2;
      if (s102_leg < 2'd2) begin
        s103_ang[1] <= s102_a1 - s102_a0;
        s103_ang[2] <= s102_a0 + s102_a1;
      end else begin
        s103_ang[1] <= s102_a0 + s102_a1;
        s103_ang[2] <= s102_a1 - s102_a0;
      end
      s103_leg <= s102_leg;
      s103_reach <= s102_reach;
    end
  end

  logic [SUM_W-1:0]         mag_q [3];
  logic [33:0]              mag_p [3];
  logic signed [CENT_W-1:0] cent_next [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag_q[j] = s103_ang[j][SUM_W-1] ? SUM_W'(-s103_ang[j]) : SUM_W'(s103_ang[j]);
      mag_p[j] = 34'(mag_q[j]) * 34'd100;
      cent_next[j] = (s103_ang[j][SUM_W-1] ^ s103_leg[0]) ?
                     -$signed({1'b0, mag_p[j][33:16]}) : $signed({1'b0, mag_p[j][33:16]});
    end
  end

  logic signed [CENT_W-1:0] s104_cent [3];
  logic [1:0]               s104_leg;
  logic                     s104_reach;

  always_ff @(posedge clk) begin
    if (en) begin
      s104_cent <= cent_next;
      s104_leg <= s103_leg;
      s104_reach <= s103_reach;
    end
  end

  // add offsets and scale to compare counts
  logic [CFG_W-1:0]         leg_offs;
  logic signed [CENT_W:0]   tgt [3];
  logic signed [31:0]       s105_n [3];
  logic [1:0]               s105_leg;
  logic                     s105_reach;

  assign leg_offs = offs[s104_leg];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      tgt[j] = (CENT_W+1)'(s104_cent[j]) + (CENT_W+1)'($signed(leg_offs[16*j +: 16]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) s105_n[j] <= 32'(tgt[j]) * PULSE_GAIN + PULSE_BIAS;
      s105_leg <= s104_leg;
      s105_reach <= s104_reach;
    end
  end

  logic [49:0] s106_prod [3];
  logic        s106_neg [3];
  logic        s106_sat [3];
  logic [1:0]  s106_leg;
  logic        s106_reach;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        s106_neg[j] <= s105_n[j] < 0;
        s106_sat[j] <= s105_n[j] >= PULSE_SAT_N;
        s106_prod[j] <= 50'(s105_n[j][24:0]) * 50'(PULSE_RECIP);
      end
      s106_leg <= s105_leg;
      s106_reach <= s105_reach;
    end
  end

  logic [PULSE_W-1:0] pulse [3];
  logic [1:0]         leg_q;
  logic               reach_q;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        if (!s106_reach || s106_neg[j]) begin
          pulse[j] <= '0;
        end else if (s106_sat[j]) begin
          pulse[j] <= PULSE_MAX;
        end else begin
          pulse[j] <= s106_prod[j][PULSE_SHIFT +: PULSE_W];
        end
      end
      leg_q <= s106_leg;
      reach_q <= s106_reach;
    end
  end

  assign out_item.leg_out = leg_q;
  assign out_item.pulse_joint_one = pulse[0];
  assign out_item.pulse_joint_two = pulse[1];
  assign out_item.pulse_joint_three = pulse[2];
  assign out_item.reachable = reach_q;
endmodule

// ===== sv/iksv_delay.sv =====
`timescale 1ns / 1ps
module iksv_delay #(
  parameter int W = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] sr [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < DEPTH; i++) sr[i] <= sr[i-1];
    end
  end

  assign q = sr[DEPTH-1];
endmodule

// ===== sv/iksv_sqrt_cell.sv =====
`timescale 1ns / 1ps
module iksv_sqrt_cell #(
  parameter int N = 16
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*N-1:0] v_in,
  input  logic [N+2:0]   rem_in,
  input  logic [N-1:0]   root_in,
  output logic [2*N-1:0] v_out,
  output logic [N+2:0]   rem_out,
  output logic [N-1:0]   root_out
);
  logic [N+2:0] sh;
  logic [N+2:0] trial;

  assign sh = {rem_in[N:0], v_in[2*N-1 -: 2]};
  assign trial = {1'b0, root_in, 2'b01};

  always_ff @(posedge clk) begin
    if (en) begin
      v_out <= {v_in[2*N-3:0], 2'b00};
      if (sh >= trial) begin
        rem_out <= sh - trial;
        root_out <= {root_in[N-2:0], 1'b1};
      end else begin
        rem_out <= sh;
        root_out <= {root_in[N-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== sv/iksv_div_cell.sv =====
`timescale 1ns / 1ps
module iksv_div_cell #(
  parameter bit FIRST = 1'b0
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [iksv_pkg::DIV_W-1:0]  rem_in,
  input  logic [iksv_pkg::DIV_W-1:0]  den_in,
  input  logic [iksv_pkg::RHO_W-1:0]  quo_in,
  output logic [iksv_pkg::DIV_W-1:0]  rem_out,
  output logic [iksv_pkg::DIV_W-1:0]  den_out,
  output logic [iksv_pkg::RHO_W-1:0]  quo_out
);
  import iksv_pkg::*;

  logic [DIV_W-1:0] sh;

  assign sh = FIRST ? rem_in : {rem_in[DIV_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      den_out <= den_in;
      if (sh >= den_in) begin
        rem_out <= sh - den_in;
        quo_out <= {quo_in[RHO_W-2:0], 1'b1};
      end else begin
        rem_out <= sh;
        quo_out <= {quo_in[RHO_W-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== sv/iksv_cordic_cell.sv =====
`timescale 1ns / 1ps
module iksv_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              en,
  input  iksv_pkg::cordic_t d,
  output iksv_pkg::cordic_t q
);
  import iksv_pkg::*;

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;

  assign dx = d.y >>> STEP;
  assign dy = d.x >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      q.zero <= d.zero;
      if (d.y > 0) begin
        q.x <= d.x + dx;
        q.y <= d.y - dy;
        q.ang <= d.ang + ATAN_TAB[STEP];
      end else begin
        q.x <= d.x - dx;
        q.y <= d.y + dy;
        q.ang <= d.ang - ATAN_TAB[STEP];
      end
    end
  end
endmodule
